// File: rtl/core/kpd_pkg.sv
package kpd_pkg;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 10;
  localparam int PHASE_W  = 3;
  localparam int TALLY_W  = 3;
  localparam int LEVEL_W  = 10;
  localparam int MS_W     = 16;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOCK_LEVEL   = 3'd0,
    REG_SILENCE_LEVEL = 3'd1,
    REG_DEBOUNCE      = 3'd2,
    REG_GROUP_GAP     = 3'd3,
    REG_PAUSE_LIMIT   = 3'd4,
    REG_SEQ_LIMIT     = 3'd5,
    REG_SUCCESS_HOLD  = 3'd6
  } reg_idx_t;

  // Register reset values
  localparam logic [LEVEL_W-1:0] KNOCK_LEVEL_RST   = 10'd200;
  localparam logic [LEVEL_W-1:0] SILENCE_LEVEL_RST = 10'd50;
  localparam logic [MS_W-1:0]    DEBOUNCE_RST      = 16'd400;
  localparam logic [MS_W-1:0]    GROUP_GAP_RST     = 16'd1200;
  localparam logic [MS_W-1:0]    PAUSE_LIMIT_RST   = 16'd3000;
  localparam logic [MS_W-1:0]    SEQ_LIMIT_RST     = 16'd8000;
  localparam logic [MS_W-1:0]    SUCCESS_HOLD_RST  = 16'd3000;

  // Knocks expected in each group
  localparam logic [TALLY_W-1:0] GROUP1_KNOCKS = 3'd2;
  localparam logic [TALLY_W-1:0] GROUP2_KNOCKS = 3'd3;
  localparam logic [TALLY_W-1:0] GROUP3_KNOCKS = 3'd1;

  // Lamp bits
  localparam int LAMP_FIRST  = 0;
  localparam int LAMP_SECOND = 1;
  localparam int LAMP_THIRD  = 2;
  localparam logic [2:0] LAMP_THIRD_MASK = 3'b100;

endpackage

// File: rtl/core/kpd_if.sv
interface kpd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [kpd_pkg::TIME_W-1:0]    time_ms;
  logic [kpd_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output time_ms, output sample, input ready);
  modport sink   (input valid, input time_ms, input sample, output ready);
endinterface

interface kpd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          knock_seen;
  logic [kpd_pkg::PHASE_W-1:0]   phase;
  logic                          led_first;
  logic                          led_second;
  logic                          led_third;

  modport source (output valid, output knock_seen, output phase, output led_first,
                  output led_second, output led_third, input ready);
  modport sink   (input valid, input knock_seen, input phase, input led_first,
                  input led_second, input led_third, output ready);
endinterface

// File: rtl/core/knock_pattern_detector.sv
// Knock pattern detector.
// samples: one word per sensor reading, carrying time_ms (free-running ms
//   stamp, wraps) and the 10-bit sample. results: one word per accepted
//   sample with knock_seen, the phase after that sample and the three LEDs.
// The secret pattern is three knock groups of 2, 3 and 1 knocks, separated
//   by pauses; success lights only the third LED.
// Throughput: one sample per cycle while no result stalls. All decisions
//   for a sample are made in one pass of compare/subtract logic from the
//   state registers, and the state is updated at the edge that accepts it.
// The result word is valid in the cycle after the sample is accepted, from
//   a single output register.
// Stall: while a result word waits and results.ready is low, samples.ready
//   drops; the result holds and no sample is lost. A waiting word that is
//   taken in the same cycle frees the register for the next sample.
// Reset (rst, synchronous): configuration returns to its defaults, phase to
//   waiting, sensor armed, lamp bits off, timers zero, no result pending.
// Configuration: cfg_we/cfg_idx/cfg_data write one register per cycle; write
//   only while idle. Indexes beyond the list are ignored.
module knock_pattern_detector (
  input  logic                           clk,
  input  logic                           rst,
  kpd_sample_if.sink                     samples,
  kpd_result_if.source                   results,
  input  logic                           cfg_we,
  input  logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kpd_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [kpd_pkg::PHASE_W-1:0] {
    PH_WAIT    = 3'd0,
    PH_GROUP1  = 3'd1,
    PH_PAUSE1  = 3'd2,
    PH_GROUP2  = 3'd3,
    PH_PAUSE2  = 3'd4,
    PH_GROUP3  = 3'd5,
    PH_SUCCESS = 3'd6
  } phase_t;

  // Configuration registers
  logic [kpd_pkg::LEVEL_W-1:0] knock_level;
  logic [kpd_pkg::LEVEL_W-1:0] silence_level;
  logic [kpd_pkg::MS_W-1:0]    debounce_ms;
  logic [kpd_pkg::MS_W-1:0]    group_gap_ms;
  logic [kpd_pkg::MS_W-1:0]    pause_limit_ms;
  logic [kpd_pkg::MS_W-1:0]    sequence_limit_ms;
  logic [kpd_pkg::MS_W-1:0]    success_hold_ms;

  // Detector state
  phase_t                      phase_reg;
  logic [kpd_pkg::TALLY_W-1:0] knock_tally;
  logic [kpd_pkg::TIME_W-1:0]  last_knock_ms;
  logic [kpd_pkg::TIME_W-1:0]  sequence_start_ms;
  logic                        armed;
  logic [2:0]                  lamp_bits;

  phase_t                      phase_next;
  logic [kpd_pkg::TALLY_W-1:0] tally_next;
  logic [kpd_pkg::TIME_W-1:0]  last_knock_next;
  logic [kpd_pkg::TIME_W-1:0]  seq_start_next;
  logic                        armed_next;
  logic [2:0]                  lamp_next;
  logic                        knocked;

  logic [kpd_pkg::TIME_W-1:0]  since_knock;
  logic [kpd_pkg::TIME_W-1:0]  since_knock_now;
  logic [kpd_pkg::TIME_W-1:0]  since_start;
  logic [kpd_pkg::TALLY_W-1:0] want;
  logic [kpd_pkg::TALLY_W-1:0] tally_cnt;
  phase_t                      close_phase;
  logic                        to_success;

  logic accept;

  // The output register is free when empty or being drained this cycle.
  assign samples.ready = !results.valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  // Wrapping time differences against the stored stamps.
  assign since_knock = samples.time_ms - last_knock_ms;
  assign since_start = samples.time_ms - sequence_start_ms;

  always_comb begin
    knocked         = 1'b0;
    phase_next      = phase_reg;
    tally_next      = knock_tally;
    last_knock_next = last_knock_ms;
    seq_start_next  = sequence_start_ms;
    armed_next      = armed;
    lamp_next       = lamp_bits;
    want            = kpd_pkg::GROUP1_KNOCKS;
    close_phase     = PH_PAUSE1;
    to_success      = 1'b0;
    tally_cnt       = knock_tally;

    // Knock detection with debounce; a knock disarms until the line goes quiet.
    if (armed) begin
      if ((samples.sample > knock_level) &&
          (since_knock > kpd_pkg::TIME_W'(debounce_ms))) begin
        knocked         = 1'b1;
        last_knock_next = samples.time_ms;
        armed_next      = 1'b0;
      end
    end else if (samples.sample < silence_level) begin
      armed_next = 1'b1;
    end

    // A fresh knock restarts the quiet interval.
    since_knock_now = knocked ? '0 : since_knock;

    case (phase_reg)
      PH_GROUP1, PH_GROUP2, PH_GROUP3: begin
        case (phase_reg)
          PH_GROUP1: begin
            want        = kpd_pkg::GROUP1_KNOCKS;
            close_phase = PH_PAUSE1;
          end
          PH_GROUP2: begin
            want        = kpd_pkg::GROUP2_KNOCKS;
            close_phase = PH_PAUSE2;
          end
          default: begin
            want        = kpd_pkg::GROUP3_KNOCKS;
            close_phase = PH_SUCCESS;
          end
        endcase

        tally_cnt = knocked ? knock_tally + 1'b1 : knock_tally;

        if (knocked && (tally_cnt > want)) begin
          // Too many knocks: drop the sequence.
          phase_next = PH_WAIT;
          tally_next = '0;
          armed_next = 1'b1;
          lamp_next  = '0;
        end else if ((since_knock_now > kpd_pkg::TIME_W'(group_gap_ms)) &&
                     (tally_cnt != '0) && armed_next) begin
          // Quiet gap closes the group.
          if (tally_cnt == want) begin
            phase_next = close_phase;
            case (close_phase)
              PH_PAUSE1: lamp_next[kpd_pkg::LAMP_FIRST]  = 1'b1;
              PH_PAUSE2: lamp_next[kpd_pkg::LAMP_SECOND] = 1'b1;
              default: begin
                to_success     = 1'b1;
                seq_start_next = samples.time_ms;
                lamp_next      = kpd_pkg::LAMP_THIRD_MASK;
              end
            endcase
          end else begin
            phase_next = PH_WAIT;
            armed_next = 1'b1;
            lamp_next  = '0;
          end
          tally_next = '0;
        end else begin
          tally_next = tally_cnt;
        end

        // Sequence timeout, measured from the first knock; skipped on the sample that reaches success.
        if (!to_success && (since_start > kpd_pkg::TIME_W'(sequence_limit_ms))) begin
          phase_next = PH_WAIT;
          tally_next = '0;
          armed_next = 1'b1;
          lamp_next  = '0;
        end
      end

      PH_PAUSE1, PH_PAUSE2: begin
        if (knocked) begin
          tally_next = 3'd1;
          phase_next = (phase_reg == PH_PAUSE1) ? PH_GROUP2 : PH_GROUP3;
        end
        if (since_knock_now > kpd_pkg::TIME_W'(pause_limit_ms)) begin
          phase_next = PH_WAIT;
          tally_next = '0;
          armed_next = 1'b1;
          lamp_next  = '0;
        end
      end

      PH_SUCCESS: begin
        // Hold, then return to waiting with only the third lamp kept.
        if (since_start > kpd_pkg::TIME_W'(success_hold_ms)) begin
          lamp_next  = lamp_bits & kpd_pkg::LAMP_THIRD_MASK;
          phase_next = PH_WAIT;
          tally_next = '0;
          armed_next = 1'b1;
        end
      end

      default: begin
        // Waiting: the first knock opens group one and starts the clock.
        if (knocked) begin
          tally_next     = 3'd1;
          seq_start_next = samples.time_ms;
          phase_next     = PH_GROUP1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knock_level       <= kpd_pkg::KNOCK_LEVEL_RST;
      silence_level     <= kpd_pkg::SILENCE_LEVEL_RST;
      debounce_ms       <= kpd_pkg::DEBOUNCE_RST;
      group_gap_ms      <= kpd_pkg::GROUP_GAP_RST;
      pause_limit_ms    <= kpd_pkg::PAUSE_LIMIT_RST;
      sequence_limit_ms <= kpd_pkg::SEQ_LIMIT_RST;
      success_hold_ms   <= kpd_pkg::SUCCESS_HOLD_RST;
      phase_reg         <= PH_WAIT;
      knock_tally       <= '0;
      last_knock_ms     <= '0;
      sequence_start_ms <= '0;
      armed             <= 1'b1;
      lamp_bits         <= '0;
      results.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          kpd_pkg::REG_KNOCK_LEVEL:   knock_level       <= cfg_data[kpd_pkg::LEVEL_W-1:0];
          kpd_pkg::REG_SILENCE_LEVEL: silence_level     <= cfg_data[kpd_pkg::LEVEL_W-1:0];
          kpd_pkg::REG_DEBOUNCE:      debounce_ms       <= cfg_data[kpd_pkg::MS_W-1:0];
          kpd_pkg::REG_GROUP_GAP:     group_gap_ms      <= cfg_data[kpd_pkg::MS_W-1:0];
          kpd_pkg::REG_PAUSE_LIMIT:   pause_limit_ms    <= cfg_data[kpd_pkg::MS_W-1:0];
          kpd_pkg::REG_SEQ_LIMIT:     sequence_limit_ms <= cfg_data[kpd_pkg::MS_W-1:0];
          kpd_pkg::REG_SUCCESS_HOLD:  success_hold_ms   <= cfg_data[kpd_pkg::MS_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        phase_reg         <= phase_next;
        knock_tally       <= tally_next;
        last_knock_ms     <= last_knock_next;
        sequence_start_ms <= seq_start_next;
        armed             <= armed_next;
        lamp_bits         <= lamp_next;
        results.valid     <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end

    // Result payload loads on accept and holds otherwise.
    if (accept) begin
      results.knock_seen <= knocked;
      results.phase      <= phase_next;
      results.led_first  <= lamp_next[kpd_pkg::LAMP_FIRST];
      results.led_second <= lamp_next[kpd_pkg::LAMP_SECOND];
      results.led_third  <= lamp_next[kpd_pkg::LAMP_THIRD];
    end
  end

  // Success shows the third lamp alone.
  a_success_lamps: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.phase == PH_SUCCESS) |->
      results.led_third && !results.led_first && !results.led_second)
    else $error("success phase with wrong lamp pattern");

  // Both earlier groups must be lit in the second pause and the third group.
  a_pause2_lamps: assert property (@(posedge clk) disable iff (rst)
    results.valid && ((results.phase == PH_PAUSE2) || (results.phase == PH_GROUP3)) |->
      results.led_first && results.led_second)
    else $error("late phase without first and second lamps");

  // A stalled result blocks new samples.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !samples.ready)
    else $error("sample accepted over a stalled result");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid after reset");

endmodule
